// ----- sv/delay_set_coprimality_scorer_defines.svh -----
// Assertion macros for the checker file of the delay set scorer.
`ifndef DELAY_SET_COPRIMALITY_SCORER_DEFINES_SVH
`define DELAY_SET_COPRIMALITY_SCORER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define DCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcs assertion failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define DCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcs assertion failed");

`endif

// ----- sv/dcs_pkg.sv -----
// Types, constants and pair tables of the delay set coprimality scorer.
`timescale 1ns / 1ps
package dcs_pkg;

    localparam int TICK_W   = 16;
    localparam int RATE_W   = 19;
    localparam int SAMPLE_W = 22;
    localparam int FIELD_W  = 17;
    localparam int INT_BITS = 28;
    localparam int PROD_W   = 35;
    localparam int SUM_W    = 31;
    localparam int TOT_W    = 38;
    localparam int DIV_DW   = 56;
    localparam int DIV_VW   = 28;

    // Constant divides use an exact reciprocal on a 31-bit operand.
    localparam int RECIP_NW = 31;
    localparam int RECIP_MW = 32;
    localparam int RECIP_PW = 63;

    localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;
    localparam logic [PROD_W-1:0] CONV_HALF = 35'd5000;

    // Dividing by 10000 is a drop of four bits and then a divide by 625.
    localparam int                  CONV_DROP   = 4;
    localparam int                  CONV_RSHIFT = 41;
    localparam logic [RECIP_MW-1:0] CONV_RECIP  = 32'd3518437209;

    localparam logic [RECIP_MW-1:0] RECIP_3        = 32'd2863311531;
    localparam int                  RECIP_3_SHIFT  = 33;
    localparam logic [RECIP_MW-1:0] RECIP_15       = 32'd2290649225;
    localparam int                  RECIP_15_SHIFT = 35;
    localparam logic [RECIP_MW-1:0] RECIP_75       = 32'd3665038760;
    localparam int                  RECIP_75_SHIFT = 38;

    typedef struct packed {
        logic [TICK_W-1:0] delay_a_ticks;
        logic [TICK_W-1:0] delay_b_ticks;
        logic [TICK_W-1:0] delay_c_ticks;
        logic [TICK_W-1:0] delay_d_ticks;
    } in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] common_factor_penalty;
        logic [FIELD_W-1:0] repeated_difference_penalty;
        logic [FIELD_W-1:0] near_period_penalty;
        logic [FIELD_W-1:0] total_penalty;
        logic               invalid_input;
    } out_t;

    typedef struct packed {
        logic [3:0][SAMPLE_W-1:0] samples;
        logic                     bad;
    } job_t;

    function automatic logic [1:0] pair_lo(input logic [2:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_hi(input logic [2:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/dcs_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module dcs_divider #(
    parameter int DW = 56,
    parameter int VW = 28
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dsr_reg;
    logic [VW:0]      trial;
    logic             qbit;
    logic [VW-1:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        qbit = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- sv/dcs_queue.sv -----
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps
module dcs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dcs_pkg::job_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output dcs_pkg::job_t pop_data
);
    dcs_pkg::job_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];
endmodule

// ----- sv/dcs_front.sv -----
// Front part: takes an item, checks it and turns the four delays into sample counts.
`timescale 1ns / 1ps
module dcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dcs_pkg::in_t                  delays,
    input  logic [dcs_pkg::RATE_W-1:0]    rate,
    input  logic                          q_full,
    output logic                          busy,
    output logic                          push,
    output dcs_pkg::job_t                 job
);
    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_t;

    fstate_t                                    state_reg;
    logic [1:0]                                 idx_reg;
    logic [3:0][dcs_pkg::TICK_W-1:0]            ticks_reg;
    logic [3:0][dcs_pkg::SAMPLE_W-1:0]          samples_reg;
    logic                                       bad_reg;
    logic [dcs_pkg::PROD_W-1:0]                 prod_reg;
    logic [dcs_pkg::RECIP_PW-1:0]               conv_prod;
    logic [dcs_pkg::SAMPLE_W-1:0]               conv_q;
    logic [dcs_pkg::SAMPLE_W-1:0]               sample;

    always_comb
    begin
        conv_prod = {{(dcs_pkg::RECIP_PW - dcs_pkg::RECIP_NW){1'b0}},
                     prod_reg[dcs_pkg::PROD_W-1:dcs_pkg::CONV_DROP]} *
                    {{(dcs_pkg::RECIP_PW - dcs_pkg::RECIP_MW){1'b0}}, dcs_pkg::CONV_RECIP};
        conv_q = conv_prod[dcs_pkg::CONV_RSHIFT +: dcs_pkg::SAMPLE_W];
        sample = (conv_q == '0) ? dcs_pkg::SAMPLE_W'(1) : conv_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            idx_reg     <= 2'd0;
            ticks_reg   <= '0;
            samples_reg <= '0;
            bad_reg     <= 1'b0;
            prod_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        ticks_reg <= {delays.delay_d_ticks, delays.delay_c_ticks,
                                      delays.delay_b_ticks, delays.delay_a_ticks};
                        bad_reg <= (rate == '0) || (delays.delay_a_ticks == '0) ||
                                   (delays.delay_b_ticks == '0) ||
                                   (delays.delay_c_ticks == '0) ||
                                   (delays.delay_d_ticks == '0);
                        idx_reg <= 2'd0;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    prod_reg <= dcs_pkg::PROD_W'(ticks_reg[idx_reg]) *
                                dcs_pkg::PROD_W'(rate) + dcs_pkg::CONV_HALF;
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    samples_reg[idx_reg] <= sample;
                    if (idx_reg == 2'd3)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        state_reg <= F_MUL;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != F_IDLE);
    assign push = (state_reg == F_PUSH) && !q_full;
    assign job = '{samples: samples_reg, bad: bad_reg};
endmodule

// ----- sv/dcs_back.sv -----
// Back part: pair penalties through a shared divider, then the averaged outputs.
`timescale 1ns / 1ps
module dcs_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    input  dcs_pkg::job_t q_data,
    output logic          pop,
    output logic          idle,
    output logic          result_valid,
    output dcs_pkg::out_t result
);
    localparam int SW = dcs_pkg::SAMPLE_W;
    localparam int DW = dcs_pkg::DIV_DW;
    localparam int VW = dcs_pkg::DIV_VW;
    localparam int NW = dcs_pkg::RECIP_NW;
    localparam int MW = dcs_pkg::RECIP_MW;
    localparam int PW = dcs_pkg::RECIP_PW;
    localparam int TMPW = dcs_pkg::TOT_W + FRACTION_BITS + 1;
    localparam logic [dcs_pkg::FIELD_W-1:0] ONE_FIELD =
        dcs_pkg::FIELD_W'(64'd1 << FRACTION_BITS);

    typedef enum logic [3:0] {
        B_IDLE, B_PAIR, B_MODW, B_GCD, B_CFW, B_NPW, B_NEXT, B_REPS,
        B_FCF, B_FNP, B_FRD, B_FTOT
    } bstate_t;

    bstate_t                    state_reg;
    dcs_pkg::job_t              job_reg;
    logic [2:0]                 pair_reg;
    logic [SW-1:0]              sm_reg;
    logic [SW-1:0]              lg_reg;
    logic [SW-1:0]              u_reg;
    logic [SW-1:0]              v_reg;
    logic [4:0]                 k_reg;
    logic [VW-1:0]              a_reg;
    logic [31:0]                b_reg;
    logic [5:0][SW-1:0]         diff_reg;
    logic [dcs_pkg::SUM_W-1:0]  cf_sum_reg;
    logic [dcs_pkg::SUM_W-1:0]  np_sum_reg;
    logic [3:0]                 reps_reg;
    logic [dcs_pkg::FIELD_W-1:0] cf_res_reg;
    logic [dcs_pkg::FIELD_W-1:0] np_res_reg;
    logic [dcs_pkg::FIELD_W-1:0] rd_res_reg;
    logic                       go_reg;
    logic [DW-1:0]              dvd_reg;
    logic [VW-1:0]              dvs_reg;
    logic                       valid_reg;
    dcs_pkg::out_t              result_reg;

    logic                       div_done;
    logic [DW-1:0]              div_q;
    logic [VW-1:0]              div_r;
    logic [SW-1:0]              s_lo;
    logic [SW-1:0]              s_hi;
    logic [SW-1:0]              rmod;
    logic [SW-1:0]              m_val;
    logic [SW-1:0]              g_val;
    logic [SW-1:0]              den;
    logic [3:0]                 reps_count;
    logic [SW-1:0]              dd;
    logic [dcs_pkg::TOT_W-1:0]  x_tot;
    logic [TMPW-1:0]            y_cf;
    logic [TMPW-1:0]            y_np;
    logic [TMPW-1:0]            y_tot;
    logic [DW-1:0]              y_rd;
    logic [NW-1:0]              fin_n;
    logic [MW-1:0]              fin_m;
    logic [5:0]                 fin_k;
    logic [PW-1:0]              fin_prod;
    logic [dcs_pkg::FIELD_W-1:0] fin_q;

    dcs_divider #(.DW(DW), .VW(VW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (go_reg),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        s_lo = job_reg.samples[dcs_pkg::pair_lo(pair_reg)];
        s_hi = job_reg.samples[dcs_pkg::pair_hi(pair_reg)];
        rmod = div_r[SW-1:0];
        m_val = ((sm_reg - rmod) < rmod) ? (sm_reg - rmod) : rmod;
        g_val = SW'(u_reg << k_reg);
        den = (sm_reg > SW'(1)) ? (sm_reg - SW'(1)) : SW'(1);
        reps_count = 4'd0;
        for (int i = 0; i < 6; i++)
        begin
            for (int j = i + 1; j < 6; j++)
            begin
                dd = (diff_reg[i] > diff_reg[j]) ? (diff_reg[i] - diff_reg[j]) :
                                                   (diff_reg[j] - diff_reg[i]);
                if (dd <= SW'(1))
                begin
                    reps_count = reps_count + 4'd1;
                end
            end
        end
        x_tot = dcs_pkg::TOT_W'(cf_sum_reg) * dcs_pkg::TOT_W'(35) +
                dcs_pkg::TOT_W'(np_sum_reg) * dcs_pkg::TOT_W'(30) +
                (dcs_pkg::TOT_W'(reps_reg) * dcs_pkg::TOT_W'(14) << dcs_pkg::INT_BITS);
        y_cf  = ((TMPW'(cf_sum_reg) << FRACTION_BITS) +
                 (TMPW'(3) << dcs_pkg::INT_BITS)) >> dcs_pkg::INT_BITS;
        y_np  = ((TMPW'(np_sum_reg) << FRACTION_BITS) +
                 (TMPW'(3) << dcs_pkg::INT_BITS)) >> dcs_pkg::INT_BITS;
        y_tot = ((TMPW'(x_tot) << FRACTION_BITS) +
                 (TMPW'(300) << dcs_pkg::INT_BITS)) >> dcs_pkg::INT_BITS;
        y_rd  = (DW'(reps_reg) << FRACTION_BITS) + DW'(7);
        unique case (state_reg)
            B_FCF:
            begin
                fin_n = NW'(y_cf >> 1);
                fin_m = dcs_pkg::RECIP_3;
                fin_k = 6'(dcs_pkg::RECIP_3_SHIFT);
            end
            B_FNP:
            begin
                fin_n = NW'(y_np >> 1);
                fin_m = dcs_pkg::RECIP_3;
                fin_k = 6'(dcs_pkg::RECIP_3_SHIFT);
            end
            B_FRD:
            begin
                fin_n = NW'(y_rd);
                fin_m = dcs_pkg::RECIP_15;
                fin_k = 6'(dcs_pkg::RECIP_15_SHIFT);
            end
            default:
            begin
                fin_n = NW'(y_tot >> 3);
                fin_m = dcs_pkg::RECIP_75;
                fin_k = 6'(dcs_pkg::RECIP_75_SHIFT);
            end
        endcase
        fin_prod = {{(PW - NW){1'b0}}, fin_n} * {{(PW - MW){1'b0}}, fin_m};
        fin_q = dcs_pkg::FIELD_W'(fin_prod >> fin_k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            job_reg    <= '0;
            pair_reg   <= '0;
            sm_reg     <= '0;
            lg_reg     <= '0;
            u_reg      <= '0;
            v_reg      <= '0;
            k_reg      <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            diff_reg   <= '0;
            cf_sum_reg <= '0;
            np_sum_reg <= '0;
            reps_reg   <= '0;
            cf_res_reg <= '0;
            np_res_reg <= '0;
            rd_res_reg <= '0;
            go_reg     <= 1'b0;
            dvd_reg    <= '0;
            dvs_reg    <= '0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        job_reg <= q_data;
                        pair_reg <= 3'd0;
                        cf_sum_reg <= '0;
                        np_sum_reg <= '0;
                        if (q_data.bad)
                        begin
                            result_reg <= '{common_factor_penalty: ONE_FIELD,
                                            repeated_difference_penalty: ONE_FIELD,
                                            near_period_penalty: ONE_FIELD,
                                            total_penalty: ONE_FIELD,
                                            invalid_input: 1'b1};
                            valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= B_PAIR;
                        end
                    end
                end
                B_PAIR:
                begin
                    sm_reg <= (s_lo < s_hi) ? s_lo : s_hi;
                    lg_reg <= (s_lo < s_hi) ? s_hi : s_lo;
                    dvd_reg <= DW'((s_lo < s_hi) ? s_hi : s_lo);
                    dvs_reg <= VW'((s_lo < s_hi) ? s_lo : s_hi);
                    go_reg <= 1'b1;
                    state_reg <= B_MODW;
                end
                B_MODW:
                begin
                    if (div_done)
                    begin
                        a_reg <= VW'(sm_reg) * VW'(35);
                        b_reg <= 32'(m_val) * 32'd1000;
                        u_reg <= lg_reg;
                        v_reg <= sm_reg;
                        k_reg <= '0;
                        state_reg <= B_GCD;
                    end
                end
                B_GCD:
                begin
                    priority if (u_reg == v_reg)
                    begin
                        dvd_reg <= DW'(g_val - SW'(1)) << dcs_pkg::INT_BITS;
                        dvs_reg <= VW'(den);
                        go_reg <= 1'b1;
                        state_reg <= B_CFW;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 5'd1;
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg <= v_reg >> 1;
                    end
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= (u_reg - v_reg) >> 1;
                    end
                    else
                    begin
                        v_reg <= (v_reg - u_reg) >> 1;
                    end
                end
                B_CFW:
                begin
                    if (div_done)
                    begin
                        cf_sum_reg <= cf_sum_reg + dcs_pkg::SUM_W'(div_q);
                        if (32'(a_reg) > b_reg)
                        begin
                            dvd_reg <= DW'(32'(a_reg) - b_reg) << dcs_pkg::INT_BITS;
                            dvs_reg <= a_reg;
                            go_reg <= 1'b1;
                            state_reg <= B_NPW;
                        end
                        else
                        begin
                            state_reg <= B_NEXT;
                        end
                    end
                end
                B_NPW:
                begin
                    if (div_done)
                    begin
                        np_sum_reg <= np_sum_reg + dcs_pkg::SUM_W'(div_q);
                        state_reg <= B_NEXT;
                    end
                end
                B_NEXT:
                begin
                    diff_reg[pair_reg] <= lg_reg - sm_reg;
                    if (pair_reg == 3'd5)
                    begin
                        state_reg <= B_REPS;
                    end
                    else
                    begin
                        pair_reg <= pair_reg + 3'd1;
                        state_reg <= B_PAIR;
                    end
                end
                B_REPS:
                begin
                    reps_reg <= reps_count;
                    state_reg <= B_FCF;
                end
                B_FCF:
                begin
                    cf_res_reg <= fin_q;
                    state_reg <= B_FNP;
                end
                B_FNP:
                begin
                    np_res_reg <= fin_q;
                    state_reg <= B_FRD;
                end
                B_FRD:
                begin
                    rd_res_reg <= fin_q;
                    state_reg <= B_FTOT;
                end
                B_FTOT:
                begin
                    result_reg <= '{common_factor_penalty: cf_res_reg,
                                    repeated_difference_penalty: rd_res_reg,
                                    near_period_penalty: np_res_reg,
                                    total_penalty: fin_q,
                                    invalid_input: 1'b0};
                    valid_reg <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign pop = (state_reg == B_IDLE) && q_not_empty;
    assign idle = (state_reg == B_IDLE) && !valid_reg;
    assign result_valid = valid_reg;
    assign result = result_reg;
endmodule

// ----- sv/delay_set_coprimality_scorer.sv -----
// Top level of the delay set coprimality scorer.
//
//  Channel  Signals                          Transfer
//  input    start, busy, delays              start high while busy is low
//  config   cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//  result   result_valid, result             result_valid high, one cycle
//
// The front is busy per item for a multiply and a reciprocal divide per delay, then for the push,
// which waits while the queue is full. The back's time per valid item is set by its shared
// divider (two or three divides per pair) and up to about 45 binary gcd steps per pair.
// An invalid item gives its result in the cycle after it leaves the queue.
// Reset is asynchronous and active low; it restores the sample rate to 48000 Hz.
// The receiver cannot stall; config is taken only with nothing in flight.
`timescale 1ns / 1ps
module delay_set_coprimality_scorer #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dcs_pkg::in_t               delays,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dcs_pkg::RATE_W-1:0] cfg_data,
    output logic                       result_valid,
    output dcs_pkg::out_t              result
);
    logic [dcs_pkg::RATE_W-1:0] rate_reg;
    logic                       q_full;
    logic                       q_not_empty;
    logic                       push;
    logic                       pop;
    logic                       back_idle;
    dcs_pkg::job_t              push_job;
    dcs_pkg::job_t              pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= dcs_pkg::RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rate_reg <= cfg_data;
        end
    end

    assign cfg_ready = !busy && !start && !q_not_empty && back_idle;

    dcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .delays (delays),
        .rate   (rate_reg),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .job    (push_job)
    );

    dcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop_data  (pop_job)
    );

    dcs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_data       (pop_job),
        .pop          (pop),
        .idle         (back_idle),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

// ----- sv/dcs_checker.sv -----
// Port-level checker of the delay set coprimality scorer and its bind.
`timescale 1ns / 1ps
`include "delay_set_coprimality_scorer_defines.svh"
module dcs_port_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic                       result_valid,
    input dcs_pkg::out_t              result
);
    `DCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `DCS_ASSERT_IMPL(a_cfg_idle, cfg_valid && cfg_ready, !busy)
    `DCS_ASSERT_IMPL(a_invalid_equal, result_valid && result.invalid_input,
        (result.common_factor_penalty == result.total_penalty) &&
        (result.near_period_penalty == result.total_penalty) &&
        (result.repeated_difference_penalty == result.total_penalty))
endmodule

bind delay_set_coprimality_scorer dcs_port_checker u_dcs_checker (.*);
